>>> src/e321_pkg.sv
// Shared constants, types and reciprocal tables for the 3-2-1 direction cosine block.
package e321_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 14;

    localparam int WORK_BITS = 30;
    localparam logic [WORK_BITS:0]   WORK_ONE  = (WORK_BITS+1)'(1) << WORK_BITS;
    localparam logic [WORK_BITS-1:0] WORK_HALF = WORK_BITS'(1) << (WORK_BITS - 1);

    localparam int PI_BITS = 34;
    localparam logic [PI_BITS-1:0] PI_Q32 = 34'h3_243F_6A89;

    localparam int RECIP_BITS   = 38;
    localparam int RECIP_SHIFT  = 38;
    localparam int HORNER_STEPS = 6;

    // Registers from angle in to sine and cosine out inside one lane.
    localparam int LANE_LAT = 4 + 3 * HORNER_STEPS + 3;

    typedef logic signed [WORK_BITS+1:0] t_trig;

    typedef struct packed {
        logic [1:0]           quad;
        logic                 swap;
        logic [WORK_BITS-1:0] x;
    } t_lane_side;

    // Reciprocals ceil(2^38 / d) for the sine series divisors.
    function automatic logic [RECIP_BITS-1:0] f_sin_recip(input int idx);
        case (idx)
            0:       return 38'd1762037866;
            1:       return 38'd2498890064;
            2:       return 38'd3817748708;
            3:       return 38'd6544712071;
            4:       return 38'd13743895348;
            default: return 38'd45812984491;
        endcase
    endfunction

    // Reciprocals ceil(2^38 / d) for the cosine series divisors.
    function automatic logic [RECIP_BITS-1:0] f_cos_recip(input int idx);
        case (idx)
            0:       return 38'd2082408386;
            1:       return 38'd3054198967;
            2:       return 38'd4908534053;
            3:       return 38'd9162596899;
            4:       return 38'd22906492246;
            default: return 38'd137438953472;
        endcase
    endfunction

endpackage

>>> src/e321_sincos.sv
// Pipelined sine and cosine of one binary angle by an octant-folded Horner series.
module e321_sincos
    import e321_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output t_trig                 o_sin,
    output t_trig                 o_cos
);

    localparam int TW     = ANGLE_BITS - 2;
    localparam int PW     = TW + PI_BITS + 1;
    localparam int RLO    = RECIP_BITS / 2;
    localparam int RHI    = RECIP_BITS - RLO;
    localparam int PL_W   = WORK_BITS + RLO;
    localparam int PH_W   = WORK_BITS + RHI;
    localparam int SUM_W  = WORK_BITS + RECIP_BITS;
    localparam int PROD_W = 2 * WORK_BITS + 1;
    localparam int NSIDE  = LANE_LAT - 2;
    localparam int NX2    = 3 * HORNER_STEPS - 2;
    localparam logic [TW-1:0] EIGHTH  = TW'(1) << (ANGLE_BITS - 3);
    localparam logic [TW:0]   QUARTER = (TW+1)'(1) << TW;

    logic [TW-1:0]         s_in;
    logic                  swap_in;
    logic [TW-1:0]         t_in;
    logic [TW-1:0]         r_t;
    logic [1:0]            r_quad0;
    logic                  r_swap0;
    logic [PW-1:0]         x_prod;
    t_lane_side            r_side [NSIDE];
    logic [2*WORK_BITS-1:0] r_xx;
    logic [WORK_BITS-1:0]  r_x2 [NX2];
    logic [PROD_W-1:0]     r_prod [HORNER_STEPS][2];
    logic [PL_W-1:0]       r_pl [HORNER_STEPS][2];
    logic [PH_W-1:0]       r_ph [HORNER_STEPS][2];
    logic [WORK_BITS:0]    r_p [HORNER_STEPS][2];
    logic [PROD_W-1:0]     r_sraw;
    logic [WORK_BITS:0]    r_cos_f1;
    logic [WORK_BITS:0]    r_sv;
    logic [WORK_BITS:0]    r_cv;
    logic [WORK_BITS:0]    sq;
    logic [WORK_BITS:0]    cq;
    t_trig                 sq_s;
    t_trig                 cq_s;
    t_lane_side            side_f3;

    assign s_in    = i_angle[TW-1:0];
    assign swap_in = s_in > EIGHTH;
    assign t_in    = swap_in ? TW'(QUARTER - {1'b0, s_in}) : s_in;
    assign x_prod  = PW'(r_t) * PW'(PI_Q32) + (PW'(1) << ANGLE_BITS);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t     <= t_in;
            r_quad0 <= i_angle[ANGLE_BITS-1 -: 2];
            r_swap0 <= swap_in;
            r_side[0].quad <= r_quad0;
            r_side[0].swap <= r_swap0;
            r_side[0].x    <= WORK_BITS'(x_prod >> (ANGLE_BITS + 1));
            for (int i = 1; i < NSIDE; i++) begin
                r_side[i] <= r_side[i-1];
            end
            r_xx    <= (2*WORK_BITS)'(r_side[0].x) * (2*WORK_BITS)'(r_side[0].x);
            r_x2[0] <= WORK_BITS'((r_xx + (2*WORK_BITS)'(WORK_HALF)) >> WORK_BITS);
            for (int i = 1; i < NX2; i++) begin
                r_x2[i] <= r_x2[i-1];
            end
        end
    end

    for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_step
        for (genvar f = 0; f < 2; f++) begin : g_fn
            localparam logic [RECIP_BITS-1:0] M = (f == 0) ? f_sin_recip(j) : f_cos_recip(j);
            logic [WORK_BITS:0]   p_in;
            logic [WORK_BITS-1:0] v;
            logic [SUM_W-1:0]     qsum;

            if (j == 0) begin : g_first
                assign p_in = WORK_ONE;
            end else begin : g_next
                assign p_in = r_p[j-1][f];
            end

            assign v    = WORK_BITS'((r_prod[j][f] + PROD_W'(WORK_HALF)) >> WORK_BITS);
            assign qsum = (SUM_W'(r_ph[j][f]) << RLO) + SUM_W'(r_pl[j][f]);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_prod[j][f] <= PROD_W'(r_x2[3*j]) * PROD_W'(p_in);
                    r_pl[j][f]   <= PL_W'(v) * PL_W'(M[RLO-1:0]);
                    r_ph[j][f]   <= PH_W'(v) * PH_W'(M[RECIP_BITS-1:RLO]);
                    r_p[j][f]    <= WORK_ONE - {1'b0, WORK_BITS'(qsum >> RECIP_SHIFT)};
                end
            end
        end
    end

    assign side_f3 = r_side[NSIDE-1];
    assign sq      = side_f3.swap ? r_cv : r_sv;
    assign cq      = side_f3.swap ? r_sv : r_cv;
    assign sq_s    = t_trig'({1'b0, sq});
    assign cq_s    = t_trig'({1'b0, cq});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sraw   <= PROD_W'(r_side[NSIDE-3].x) * PROD_W'(r_p[HORNER_STEPS-1][0]);
            r_cos_f1 <= r_p[HORNER_STEPS-1][1];
            r_sv     <= (WORK_BITS+1)'((r_sraw + PROD_W'(WORK_HALF)) >> WORK_BITS);
            r_cv     <= r_cos_f1;
            case (side_f3.quad)
                2'd0: begin
                    o_sin <= sq_s;
                    o_cos <= cq_s;
                end
                2'd1: begin
                    o_sin <= cq_s;
                    o_cos <= -sq_s;
                end
                2'd2: begin
                    o_sin <= -sq_s;
                    o_cos <= -cq_s;
                end
                default: begin
                    o_sin <= -cq_s;
                    o_cos <= sq_s;
                end
            endcase
        end
    end

endmodule

>>> src/euler_321_direction_cosine.sv
// Top level: yaw-pitch-roll (3-2-1) direction cosine matrix from three binary angles.
//
// Input channel (s_axis): one word holds yaw, pitch and roll, each a binary angle
// where 2^ANGLE_BITS is one full turn. Output channel (m_axis): one word holds the
// nine matrix entries m00 to m22, each a signed fixed-point value in which
// 2^FRACTION_BITS means 1.0, saturated to plus or minus 1.0.
// Each accepted word gives exactly one result word, in order.
// From acceptance to the result being presented, a word passes the sine and cosine
// lanes, whose depth is set by the six-step Horner series with three registers per
// step, then the matrix product and sum registers, and the output register.
// Throughput is one word per cycle while the skid register is empty.
// A skid register behind the output register lets the pipeline deliver one more
// result while the receiver stalls; once it is full the whole pipeline holds and
// s_axis_tready falls until the receiver takes a word. Nothing is lost or repeated.
// Reset is synchronous and active low; it empties the pipeline and the output.
module euler_321_direction_cosine
    import e321_pkg::*;
#(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // yaw_angle, pitch_angle, roll_angle; zero padding above.
    input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22; zero padding above.
    output logic [((9*(FRACTION_BITS+2)+7)/8)*8-1:0] o_m_axis_tdata
);

    localparam int RES_W    = FRACTION_BITS + 2;
    localparam int OUT_W    = ((9*RES_W+7)/8)*8;
    localparam int PIPE_LAT = LANE_LAT + 6;
    localparam int MAG_W    = WORK_BITS + 1;
    localparam int RAW_W    = 2 * MAG_W;
    localparam int SH       = WORK_BITS - FRACTION_BITS;
    localparam int SUM_W    = WORK_BITS + 3;
    localparam logic [SUM_W-1:0] FULL = SUM_W'(1) << FRACTION_BITS;

    typedef struct packed {
        logic             neg;
        logic [RAW_W-1:0] mag;
    } t_prod;

    typedef logic signed [SUM_W-1:0] t_sum;

    function automatic t_prod f_mul(input t_trig a, input t_trig b);
        t_prod            p;
        logic [MAG_W-1:0] ma;
        logic [MAG_W-1:0] mb;
        ma    = a[WORK_BITS+1] ? MAG_W'(-a) : MAG_W'(a);
        mb    = b[WORK_BITS+1] ? MAG_W'(-b) : MAG_W'(b);
        p.neg = a[WORK_BITS+1] ^ b[WORK_BITS+1];
        p.mag = RAW_W'(ma) * RAW_W'(mb);
        return p;
    endfunction

    function automatic t_trig f_round(input t_prod p);
        t_trig m;
        m = t_trig'({1'b0, MAG_W'((p.mag + RAW_W'(WORK_HALF)) >> WORK_BITS)});
        return p.neg ? -m : m;
    endfunction

    function automatic logic [RES_W-1:0] f_to_res(input t_sum v);
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] r;
        mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
        r   = (mag + (SUM_W'(1) << (SH - 1))) >> SH;
        if (r > FULL) begin
            r = FULL;
        end
        return v[SUM_W-1] ? RES_W'(-r) : RES_W'(r);
    endfunction

    logic              en;
    logic [PIPE_LAT-1:0] r_vld;
    t_trig             trig [6];
    t_trig             r_t1 [6];
    t_trig             r_t2 [6];
    t_prod             r_p_srst;
    t_prod             r_p_crst;
    t_trig             r_srst;
    t_trig             r_crst;
    t_prod             r_pr [12];
    t_trig             r_rd [12];
    t_trig             r_nst3;
    t_trig             r_nst4;
    t_sum              r_sum [9];
    logic [RES_W-1:0]  r_res [9];
    logic [OUT_W-1:0]  res_pack;
    logic [OUT_W-1:0]  r_out_data;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_skid_data;
    logic              r_skid_valid;
    logic              pipe_take;

    assign en              = !r_skid_valid;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign pipe_take       = en && r_vld[PIPE_LAT-1];

    e321_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_s_axis_tdata[ANGLE_BITS-1:0]),
        .o_sin   (trig[0]),
        .o_cos   (trig[1])
    );

    e321_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS]),
        .o_sin   (trig[2]),
        .o_cos   (trig[3])
    );

    e321_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_s_axis_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]),
        .o_sin   (trig[4]),
        .o_cos   (trig[5])
    );

    // Trig order: sin yaw, cos yaw, sin pitch, cos pitch, sin roll, cos roll.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1     <= trig;
            r_p_srst <= f_mul(trig[4], trig[2]);
            r_p_crst <= f_mul(trig[5], trig[2]);
            r_t2     <= r_t1;
            r_srst   <= f_round(r_p_srst);
            r_crst   <= f_round(r_p_crst);
            r_pr[0]  <= f_mul(r_t2[3], r_t2[1]);
            r_pr[1]  <= f_mul(r_t2[3], r_t2[0]);
            r_pr[2]  <= f_mul(r_srst, r_t2[1]);
            r_pr[3]  <= f_mul(r_t2[5], r_t2[0]);
            r_pr[4]  <= f_mul(r_srst, r_t2[0]);
            r_pr[5]  <= f_mul(r_t2[5], r_t2[1]);
            r_pr[6]  <= f_mul(r_t2[4], r_t2[3]);
            r_pr[7]  <= f_mul(r_crst, r_t2[1]);
            r_pr[8]  <= f_mul(r_t2[4], r_t2[0]);
            r_pr[9]  <= f_mul(r_crst, r_t2[0]);
            r_pr[10] <= f_mul(r_t2[4], r_t2[1]);
            r_pr[11] <= f_mul(r_t2[5], r_t2[3]);
            r_nst3   <= -r_t2[2];
            for (int i = 0; i < 12; i++) begin
                r_rd[i] <= f_round(r_pr[i]);
            end
            r_nst4   <= r_nst3;
            r_sum[0] <= t_sum'(r_rd[0]);
            r_sum[1] <= t_sum'(r_rd[1]);
            r_sum[2] <= t_sum'(r_nst4);
            r_sum[3] <= t_sum'(r_rd[2]) - t_sum'(r_rd[3]);
            r_sum[4] <= t_sum'(r_rd[4]) + t_sum'(r_rd[5]);
            r_sum[5] <= t_sum'(r_rd[6]);
            r_sum[6] <= t_sum'(r_rd[7]) + t_sum'(r_rd[8]);
            r_sum[7] <= t_sum'(r_rd[9]) - t_sum'(r_rd[10]);
            r_sum[8] <= t_sum'(r_rd[11]);
            for (int i = 0; i < 9; i++) begin
                r_res[i] <= f_to_res(r_sum[i]);
            end
        end
    end

    assign res_pack = OUT_W'({r_res[8], r_res[7], r_res[6], r_res[5], r_res[4],
                              r_res[3], r_res[2], r_res[1], r_res[0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[PIPE_LAT-2:0], i_s_axis_tvalid};
            end
            if (r_skid_valid) begin
                if (i_m_axis_tready) begin
                    r_out_data   <= r_skid_data;
                    r_skid_valid <= 1'b0;
                end
            end else if (pipe_take) begin
                if (!r_out_valid || i_m_axis_tready) begin
                    r_out_data  <= res_pack;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_data  <= res_pack;
                    r_skid_valid <= 1'b1;
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("Skid register holds a word while the output register is empty.");

    a_skid_catch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pipe_take && r_out_valid && !i_m_axis_tready) |=> r_skid_valid)
        else $error("A finished word was dropped while the receiver stalled.");

    a_skid_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_m_axis_tready))
        else $error("Skid register filled although the output could drain.");

    a_m00_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($signed(r_out_data[RES_W-1:0]) <= $signed(FULL[RES_W-1:0]))
                        && ($signed(r_out_data[RES_W-1:0]) >= -$signed(FULL[RES_W-1:0])))
        else $error("Entry m00 lies outside plus or minus one.");
`endif

endmodule
